### design/ecs_pkg.sv
// ecs_pkg: shared widths, codes and types of the 3x3 edge contrast suppressor.
// No dependencies; imported by ecs_contrast and edge_contrast_suppress_3x3.
`default_nettype none

package ecs_pkg;

   localparam int PIX_W         = 8;
   localparam int THR_W         = 11;
   localparam int WREG_W        = 11;
   localparam int ROW_W         = 13;
   localparam int CSR_W         = 13;
   localparam int CSR_IDX_W     = 2;
   localparam int PSUM_W        = 9;
   localparam int SUM_W         = 11;
   localparam int DEF_MAX_WIDTH = 1024;

   localparam logic [PIX_W-1:0]  EDGE_MARK     = 8'd255;
   localparam logic [THR_W-1:0]  RST_THRESHOLD = 11'd0;
   localparam logic [WREG_W-1:0] RST_WIDTH     = 11'd1024;
   localparam logic [ROW_W-1:0]  RST_HEIGHT    = 13'd768;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WIDTH     = 2'd1,
      CSR_HEIGHT    = 2'd2
   } csr_idx_type;

   // 3x3 gray window, [row][col], row 0 is the oldest line
   typedef logic [2:0][2:0][PIX_W-1:0] win_type;

   typedef logic [3:0][PSUM_W-1:0] psum_type;

endpackage

`default_nettype wire

### design/ecs_ram.sv
// ecs_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module ecs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/ecs_contrast.sv
// ecs_contrast: sum of absolute differences between window centre and its 8 neighbors.
// Depends on ecs_pkg. Partial sums registered, final add combinational.
`default_nettype none

module ecs_contrast (
   input  logic                      clock,
   input  logic                      advance,
   input  ecs_pkg::win_type          win,
   output logic [ecs_pkg::SUM_W-1:0] sum
);

   import ecs_pkg::*;

   function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [7:0][PIX_W-1:0] diff;
   logic [PIX_W-1:0]      centre;
   psum_type              psum_in;
   psum_type              psum_ff;

   always_comb begin
      centre  = win[1][1];
      diff[0] = absdiff(win[0][0], centre);
      diff[1] = absdiff(win[0][1], centre);
      diff[2] = absdiff(win[0][2], centre);
      diff[3] = absdiff(win[1][0], centre);
      diff[4] = absdiff(win[1][2], centre);
      diff[5] = absdiff(win[2][0], centre);
      diff[6] = absdiff(win[2][1], centre);
      diff[7] = absdiff(win[2][2], centre);
      for (int k = 0; k < 4; k++) begin
         psum_in[k] = PSUM_W'(diff[2*k]) + PSUM_W'(diff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         psum_ff <= psum_in;
      end
   end

   assign sum = SUM_W'(psum_ff[0]) + SUM_W'(psum_ff[1])
              + SUM_W'(psum_ff[2]) + SUM_W'(psum_ff[3]);

endmodule

`default_nettype wire

### design/edge_contrast_suppress_3x3.sv
// Streaming 3x3 edge clean-up: a result passes the stage registers and output register after
// its beat is accepted; while req_stall is low, one beat per clock is taken, set by the one
// line memory read and one write-back per pixel beat.
// A pixel beat releases the edge of the pixel W+1 positions earlier; flush beats drain only at a frame start.
// Synchronous reset clears counters, pipeline valids and registers to their defaults;
// memories are not cleared, every entry that affects a result was written first.
// Register writes are expected while the stream is drained. Depends on ecs_pkg, ecs_ram,
// ecs_contrast.
`default_nettype none

module edge_contrast_suppress_3x3 #(
   parameter int MAX_WIDTH = ecs_pkg::DEF_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [ecs_pkg::PIX_W-1:0]     req_gray_value,
   input  logic [ecs_pkg::PIX_W-1:0]     req_edge_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ecs_pkg::PIX_W-1:0]     rsp_edge_out,
   output logic                          rsp_last_of_frame,
   input  logic                          csr_we,
   input  logic [ecs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ecs_pkg::CSR_W-1:0]     csr_wdata
);

   import ecs_pkg::*;

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int EDEPTH = MAX_WIDTH + 2;
   localparam int EAW    = $clog2(EDEPTH);
   localparam int PW     = $clog2(MAX_WIDTH + 3);

   typedef struct packed {
      logic             check;
      logic [PIX_W-1:0] edge_v;
      logic             last;
   } stage_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_v;
      logic             last;
   } result_type;

   function automatic logic [WW-1:0] eff_width(input logic [WREG_W-1:0] v);
      logic [WW-1:0] r;
      if (v == '0) begin
         r = WW'(1);
      end else if (32'(v) > MAX_WIDTH) begin
         r = WW'(MAX_WIDTH);
      end else begin
         r = WW'(v);
      end
      return r;
   endfunction

   // configuration
   logic [THR_W-1:0] thr_ff;
   logic [WW-1:0]    w_eff_ff;
   logic [ROW_W-1:0] h_eff_ff;

   // input side counters and queue pointers
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0]    ecol_ff, ecol_in;
   logic [ROW_W-1:0] erow_ff, erow_in;
   logic [PW-1:0]    pending_ff, pending_in;
   logic [EAW-1:0]   ewr_ff, ewr_in;
   logic [EAW-1:0]   erd_ff, erd_in;

   logic adv, in_acc, is_pix, emit_s0, inner_s0, last_s0;

   // stage 1
   logic             s1_pix_ff, s1_emit_ff, s1_inner_ff, s1_last_ff;
   logic [PIX_W-1:0] s1_gray_ff;
   logic [CW-1:0]    s1_col_ff;

   // line memory: {gray two rows up, gray one row up}
   logic                 lm_we, lm_re;
   logic [2*PIX_W-1:0]   lm_wdata, lm_rdata;
   logic                 fwd_hit_ff;
   logic [2*PIX_W-1:0]   fwd_data_ff;
   logic [PIX_W-1:0]     line_r2, line_r1;

   logic                 em_we, em_re;
   logic [PIX_W-1:0]     em_rdata;

   win_type              win_ff;

   logic                 s2_emit_ff, s3_emit_ff;
   stage_type            s2_ff, s3_ff;
   logic [SUM_W-1:0]     ctr_sum;
   result_type           res;

   logic                 main_valid_ff, skid_valid_ff;
   result_type           main_ff, skid_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= RST_THRESHOLD;
         w_eff_ff <= eff_width(RST_WIDTH);
         h_eff_ff <= RST_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_THRESHOLD: thr_ff <= csr_wdata[THR_W-1:0];
            CSR_WIDTH:     w_eff_ff <= eff_width(csr_wdata[WREG_W-1:0]);
            CSR_HEIGHT:    h_eff_ff <= (csr_wdata == '0) ? ROW_W'(1) : csr_wdata[ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- stage 0: accept ----------------
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign in_acc    = req_valid && adv;
   assign is_pix    = (op_type'(req_operation) == OP_PIXEL);

   // flush drains only at a frame start
   assign emit_s0 = is_pix ? (32'(pending_ff) > 32'(w_eff_ff))
                           : ((pending_ff != '0) && (col_ff == '0) && (row_ff == '0));

   assign inner_s0 = (erow_ff != '0) && (32'(erow_ff) + 1 < 32'(h_eff_ff))
                  && (ecol_ff != '0) && (32'(ecol_ff) + 1 < 32'(w_eff_ff));
   assign last_s0  = (32'(ecol_ff) + 1 == 32'(w_eff_ff))
                  && (32'(erow_ff) + 1 == 32'(h_eff_ff));

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      ecol_in    = ecol_ff;
      erow_in    = erow_ff;
      pending_in = pending_ff;
      ewr_in     = ewr_ff;
      erd_in     = erd_ff;
      if (in_acc) begin
         if (is_pix) begin
            if (WW'(col_ff) + WW'(1) == w_eff_ff) begin
               col_in = '0;
               row_in = (row_ff + ROW_W'(1) == h_eff_ff) ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
            ewr_in = (ewr_ff == EAW'(EDEPTH - 1)) ? '0 : ewr_ff + EAW'(1);
         end
         if (emit_s0) begin
            erd_in = (erd_ff == EAW'(EDEPTH - 1)) ? '0 : erd_ff + EAW'(1);
            if (WW'(ecol_ff) + WW'(1) == w_eff_ff) begin
               ecol_in = '0;
               erow_in = (erow_ff + ROW_W'(1) == h_eff_ff) ? '0 : erow_ff + ROW_W'(1);
            end else begin
               ecol_in = ecol_ff + CW'(1);
            end
         end
         pending_in = pending_ff + PW'(is_pix) - PW'(emit_s0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         ecol_ff    <= '0;
         erow_ff    <= '0;
         pending_ff <= '0;
         ewr_ff     <= '0;
         erd_ff     <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         ecol_ff    <= ecol_in;
         erow_ff    <= erow_in;
         pending_ff <= pending_in;
         ewr_ff     <= ewr_in;
         erd_ff     <= erd_in;
      end
   end

   // ---------------- memories ----------------
   assign lm_re    = in_acc && is_pix;
   assign lm_we    = adv && s1_pix_ff;
   assign lm_wdata = {line_r1, s1_gray_ff};

   ecs_ram #(
      .WIDTH (2*PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (lm_we),
      .wr_addr (s1_col_ff),
      .wr_data (lm_wdata),
      .rd_en   (lm_re),
      .rd_addr (col_ff),
      .rd_data (lm_rdata)
   );

   // same column read while being written back (one-pixel rows)
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (lm_re) begin
         fwd_hit_ff <= lm_we && (col_ff == s1_col_ff);
      end
      if (lm_re) begin
         fwd_data_ff <= lm_wdata;
      end
   end

   assign {line_r2, line_r1} = fwd_hit_ff ? fwd_data_ff : lm_rdata;

   assign em_we = in_acc && is_pix;
   assign em_re = in_acc && emit_s0;

   ecs_ram #(
      .WIDTH (PIX_W),
      .DEPTH (EDEPTH)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (em_we),
      .wr_addr (ewr_ff),
      .wr_data (req_edge_value),
      .rd_en   (em_re),
      .rd_addr (erd_ff),
      .rd_data (em_rdata)
   );

   // ---------------- stage 1: line data back, window shift ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pix_ff  <= 1'b0;
         s1_emit_ff <= 1'b0;
      end else if (adv) begin
         s1_pix_ff  <= in_acc && is_pix;
         s1_emit_ff <= in_acc && emit_s0;
      end
      if (adv) begin
         s1_gray_ff  <= req_gray_value;
         s1_col_ff   <= col_ff;
         s1_inner_ff <= inner_s0;
         s1_last_ff  <= last_s0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_pix_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= line_r2;
         win_ff[1][2] <= line_r1;
         win_ff[2][2] <= s1_gray_ff;
      end
   end

   // ---------------- stages 2 and 3: contrast sum and decision ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
         s3_emit_ff <= 1'b0;
      end else if (adv) begin
         s2_emit_ff <= s1_emit_ff;
         s3_emit_ff <= s2_emit_ff;
      end
      if (adv) begin
         s2_ff.check  <= s1_inner_ff && (em_rdata == EDGE_MARK);
         s2_ff.edge_v <= em_rdata;
         s2_ff.last   <= s1_last_ff;
         s3_ff        <= s2_ff;
      end
   end

   ecs_contrast u_contrast (
      .clock   (clock),
      .advance (adv),
      .win     (win_ff),
      .sum     (ctr_sum)
   );

   always_comb begin
      res.edge_v = (s3_ff.check && (ctr_sum < thr_ff)) ? '0 : s3_ff.edge_v;
      res.last   = s3_ff.last;
   end

   // ---------------- output register with skid ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (adv) begin
         if (!main_valid_ff || !rsp_stall) begin
            main_valid_ff <= s3_emit_ff;
         end else if (s3_emit_ff) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (!rsp_stall) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (!main_valid_ff || !rsp_stall) begin
            main_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end else if (!rsp_stall) begin
         main_ff <= skid_ff;
      end
   end

   assign rsp_valid         = main_valid_ff;
   assign rsp_edge_out      = main_ff.edge_v;
   assign rsp_last_of_frame = main_ff.last;

   // ---------------- assertions ----------------
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without an output beat");

   a_empty_queue_ptrs: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == '0) |-> (erd_ff == ewr_ff))
      else $error("edge queue pointers disagree with pending count");

   a_no_edge_collision: assert property (@(posedge clock) disable iff (reset)
      (in_acc && is_pix && emit_s0) |-> (erd_ff != ewr_ff))
      else $error("edge queue read and write hit the same entry");

   a_pending_moves_with_ptrs: assert property (@(posedge clock) disable iff (reset)
      (em_re && !em_we) |=> (pending_ff == $past(pending_ff) - PW'(1)))
      else $error("drain beat did not reduce pending count");

endmodule

`default_nettype wire

### tb/sv/edge_contrast_suppress_3x3_tb.sv
// Testbench for edge_contrast_suppress_3x3: random and directed raster frames, with a
// scoreboard class that predicts each cleaned edge value. Depends on ecs_pkg and the RTL.
`timescale 1ns / 1ps

import ecs_pkg::*;

typedef struct packed {
   logic [PIX_W-1:0] edge_out;
   logic             last_px;
} edge_result_type;

class edge_cleanup_checker;
   logic [THR_W-1:0]  threshold;
   logic [WREG_W-1:0] width_reg;
   logic [ROW_W-1:0]  height_reg;
   logic [PIX_W-1:0]  gray_hist [4096];
   logic [11:0]       gray_wr;
   logic [PIX_W-1:0]  edge_line [$];
   int unsigned       col, row, emitted;
   edge_result_type   expected_edges [$];
   int                mismatches;

   function new();
      threshold  = RST_THRESHOLD;
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      foreach (gray_hist[i]) gray_hist[i] = '0;
      gray_wr    = '0;
      col        = 0;
      row        = 0;
      emitted    = 0;
      mismatches = 0;
   endfunction

   function int unsigned width_eff();
      if (width_reg == 0) return 1;
      if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return width_reg;
   endfunction

   function int unsigned height_eff();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function int outstanding();
      return expected_edges.size();
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      case (idx)
         CSR_THRESHOLD: threshold = data[THR_W-1:0];
         CSR_WIDTH:     width_reg = data[WREG_W-1:0];
         CSR_HEIGHT:    height_reg = data[ROW_W-1:0];
         default: ;
      endcase
   endfunction

   // oldest pending pixel leaves; interior edges get the 3x3 contrast test
   function void release_edge();
      int unsigned w, h, total, r, c, diff_sum;
      logic [11:0] centre_at;
      logic [PIX_W-1:0] edge_v, centre_v, nb;
      edge_result_type item;
      w = width_eff();
      h = height_eff();
      total = w * h;
      centre_at = gray_wr - 12'(edge_line.size());
      edge_v = edge_line.pop_front();
      if (emitted >= total) emitted = 0;
      r = emitted / w;
      c = emitted % w;
      if (edge_v == EDGE_MARK && r >= 1 && r + 1 < h && c >= 1 && c + 1 < w) begin
         centre_v = gray_hist[centre_at];
         diff_sum = 0;
         for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
               nb = gray_hist[centre_at + 12'(dr * int'(w) + dc)];
               diff_sum += (nb > centre_v) ? nb - centre_v : centre_v - nb;
            end
         end
         if (diff_sum < threshold) edge_v = '0;
      end
      item.edge_out = edge_v;
      item.last_px  = (emitted + 1 == total);
      expected_edges.insert(expected_edges.size(), item);
      emitted++;
      if (emitted >= total) emitted = 0;
   endfunction

   function void note_beat(logic op, logic [PIX_W-1:0] gray, logic [PIX_W-1:0] edge_v);
      int unsigned w, h;
      w = width_eff();
      h = height_eff();
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      if (op == OP_FLUSH) begin
         // flush only drains when the input sits at a frame start
         if (edge_line.size() != 0 && col == 0 && row == 0) release_edge();
         return;
      end
      gray_hist[gray_wr] = gray;
      gray_wr++;
      edge_line.insert(edge_line.size(), edge_v);
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      if (edge_line.size() > w + 1) release_edge();
   endfunction

   task report(string what);
      if (mismatches < 50) $display("[%0t] edge mismatch: %s", $time, what);
      mismatches++;
   endtask

   task check_result(logic [PIX_W-1:0] edge_out, logic last_px);
      edge_result_type want;
      if (expected_edges.size() == 0) begin
         report($sformatf("unexpected beat edge_out=%0d last=%0b", edge_out, last_px));
         return;
      end
      want = expected_edges.pop_front();
      if (edge_out !== want.edge_out)
         report($sformatf("edge_out got %0d want %0d", edge_out, want.edge_out));
      if (last_px !== want.last_px)
         report($sformatf("last_of_frame got %0b want %0b", last_px, want.last_px));
   endtask
endclass

module edge_contrast_suppress_3x3_tb;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int PIPE_SLACK   = 10;
   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_ITEMS = 700;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_operation;
   logic [PIX_W-1:0]     req_gray_value;
   logic [PIX_W-1:0]     req_edge_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [PIX_W-1:0]     rsp_edge_out;
   logic                 rsp_last_of_frame;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   edge_cleanup_checker chk = new();
   int  cycle_count = 0;
   int  pixels_sent = 0;
   bit  sender_quiet = 1'b0;
   bit  hold_rsp = 1'b0;

   edge_contrast_suppress_3x3 i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_gray_value    (req_gray_value),
      .req_edge_value    (req_edge_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_edge_out      (rsp_edge_out),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) chk.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            chk.note_beat(req_operation, req_gray_value, req_edge_value);
         if (rsp_valid && !rsp_stall) chk.check_result(rsp_edge_out, rsp_last_of_frame);
      end
   end

   // mostly short gaps, a few long ones
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver side: random stall bursts, quiet stretches, one long hold on request
   initial begin
      int left;
      int since;
      bit quiet;
      left = 0;
      since = 0;
      quiet = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end
         since++;
         if (since >= 200) begin
            since = 0;
            quiet = ($urandom_range(0, 3) == 0);
         end
         if (left == 0 && !quiet) left = idle_span();
         if (left > 0) begin
            rsp_stall <= 1'b1;
            left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_beat(input op_type op, input logic [PIX_W-1:0] gray,
                            input logic [PIX_W-1:0] edge_v);
      int gap;
      gap = sender_quiet ? 0 : idle_span();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_gray_value <= gray;
      req_edge_value <= edge_v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle(input int slack);
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (chk.outstanding() != 0) @(posedge clock);
      repeat (slack) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] pick_gray(input int base, input int spread);
      int v;
      if (spread >= 255) return PIX_W'($urandom);
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return PIX_W'(v);
   endfunction

   function automatic logic [PIX_W-1:0] pick_edge();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return EDGE_MARK;
      if (r < 80) return '0;
      return PIX_W'($urandom);
   endfunction

   task automatic send_frame(input int pause_idx);
      int w, h, spread, base, r;
      w = chk.width_eff();
      h = chk.height_eff();
      r = $urandom_range(0, 3);
      spread = (r == 0) ? 3 : (r == 1) ? 20 : (r == 2) ? 80 : 255;
      base = $urandom_range(0, 255);
      sender_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < w * h; i++) begin
         // stray flushes: ignored mid-frame, drain at a frame start
         if ($urandom_range(0, 99) < 3) send_beat(OP_FLUSH, PIX_W'($urandom), PIX_W'($urandom));
         if (i == pause_idx) settle(0);
         send_beat(OP_PIXEL, pick_gray(base, spread), pick_edge());
         pixels_sent++;
      end
      sender_quiet = 1'b0;
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] thr, input logic [CSR_W-1:0] wd,
                            input logic [CSR_W-1:0] ht, input int frames,
                            input int pause_idx, input bit hold);
      settle(PIPE_SLACK);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_WIDTH, wd);
      write_reg(CSR_HEIGHT, ht);
      if (hold) hold_rsp = 1'b1;
      for (int f = 0; f < frames; f++) send_frame((f == 0) ? pause_idx : -1);
      repeat (chk.width_eff() + 1 + $urandom_range(0, 2))
         send_beat(OP_FLUSH, PIX_W'($urandom), PIX_W'($urandom));
   endtask

   initial begin
      // frame A: centre 0 among 255s, sum 2040 equals the threshold so the edge stays
      // frame B: sum 2039, just under the threshold, so the centre edge is cleared
      logic [PIX_W-1:0] gray_a [9] = '{255, 255, 255, 255, 0, 255, 255, 255, 255};
      logic [PIX_W-1:0] edge_a [9] = '{255, 0, 1, 128, 255, 254, 255, 255, 0};
      logic [PIX_W-1:0] gray_b [9] = '{0, 0, 0, 0, 255, 0, 0, 0, 1};
      int random_start, phase_no, r;
      logic [CSR_W-1:0] thr, wd, ht;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_PIXEL;
      req_gray_value = '0;
      req_edge_value = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_THRESHOLD;
      csr_wdata      = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames
      write_reg(CSR_WIDTH, 13'd3);
      write_reg(CSR_HEIGHT, 13'd3);
      write_reg(CSR_THRESHOLD, 13'd2040);
      write_reg(CSR_SPARE, CSR_W'($urandom));
      send_beat(OP_FLUSH, 8'd0, 8'd255);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_beat(OP_FLUSH, 8'd255, 8'd0);
         send_beat(OP_PIXEL, gray_a[i], edge_a[i]);
      end
      for (int i = 0; i < 9; i++) send_beat(OP_PIXEL, gray_b[i], EDGE_MARK);
      repeat (5) send_beat(OP_FLUSH, 8'd0, 8'd0);

      // register extremes: longer line at top threshold, width 0 and height 0, small frames
      run_phase(13'd2047, 13'd40, 13'd3, 1, -1, 1'b0);
      run_phase(13'd0, 13'd0, 13'd0, 2, -1, 1'b0);
      run_phase(13'd0, 13'd5, 13'd5, 2, -1, 1'b0);

      random_start = pixels_sent;
      phase_no = 0;
      while (pixels_sent - random_start < RANDOM_ITEMS) begin
         phase_no++;
         r = $urandom_range(0, 9);
         thr = CSR_W'((r < 5) ? $urandom_range(0, 400) :
                      (r < 8) ? $urandom_range(0, 2047) : (r == 8) ? 0 : 2047);
         thr[CSR_W-1:THR_W] = (CSR_W-THR_W)'($urandom);
         wd = CSR_W'(($urandom_range(0, 9) < 2) ? $urandom_range(0, 2)
                                                 : $urandom_range(3, 12));
         wd[CSR_W-1:WREG_W] = (CSR_W-WREG_W)'($urandom);
         ht = CSR_W'($urandom_range(0, 6));
         if (phase_no == 2)
            run_phase(thr, 13'd8, 13'd6, 2, -1, 1'b1);
         else if (phase_no == 3)
            run_phase(thr, 13'd6, 13'd5, 1, 14, 1'b0);
         else
            run_phase(thr, wd, ht, $urandom_range(1, 3), -1, 1'b0);
      end

      settle(PIPE_SLACK);
      if (chk.mismatches == 0 && chk.outstanding() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
